FILE: hdl/hpt_pkg.sv
// hpt_pkg: shared types and constants for the hashed position table
// no dependencies; imported by every module of the block
package hpt_pkg;

  // table size must be a power of two: the slot is the low key bits
  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

  localparam int MATE_SCORE  = 32000;
  localparam int NONE_SCORE  = 32001;
  localparam int MATE_WINDOW = 500;

  localparam logic [15:0]        EMPTY_MOVE = 16'd0;
  localparam logic signed [15:0] NONE_VAL   = 16'(NONE_SCORE);

  // mate window bounds and saturation limits, 17-bit signed
  localparam logic signed [16:0] MATE_HI = 17'(MATE_SCORE - MATE_WINDOW);
  localparam logic signed [16:0] MATE_LO = 17'(MATE_WINDOW - MATE_SCORE);
  localparam logic signed [16:0] SAT_MAX = 17'sd32767;
  localparam logic signed [16:0] SAT_MIN = -17'sd32768;

  // command codes
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_PROBE = 1'b1;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic               cmd;
    logic [63:0]        key;
    logic [15:0]        best_move;
    logic signed [15:0] score;
    logic signed [15:0] static_score;
    logic [7:0]         search_depth;
    logic [1:0]         bound_kind;
    logic [7:0]         entry_age;
    logic               on_pv;
    logic [7:0]         ply_from_root;
  } hpt_in_t;

  typedef struct packed {
    logic               hit;
    logic [15:0]        found_move;
    logic signed [15:0] found_score;
    logic signed [15:0] found_static_score;
    logic signed [15:0] found_depth;
    logic [1:0]         found_bound;
    logic               found_pv;
  } hpt_out_t;

  // classified command as it sits in the queue
  typedef struct packed {
    logic               is_probe;
    logic [63:0]        key;
    logic [15:0]        move;
    logic signed [15:0] score;
    logic signed [15:0] static_score;
    logic [7:0]         depth;
    logic [1:0]         bound;
    logic [7:0]         age;
    logic               pv;
  } hpt_op_t;

  // per-entry metadata word
  typedef struct packed {
    logic [15:0] move;
    logic [7:0]  depth;
    logic [1:0]  bound;
    logic [7:0]  age;
    logic        pv;
    logic        valid;
  } hpt_meta_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hpt_qstat_t;

endpackage

FILE: hdl/hpt_front.sv
// hpt_front: command acceptance, classification and mate score adjustment
// depends on hpt_pkg
module hpt_front import hpt_pkg::*; (
  input  logic       start_i,
  input  hpt_in_t    item_i,
  input  hpt_qstat_t qstat_i,
  input  logic       clearing_i,
  output logic       busy_o,
  output logic       push_o,
  output hpt_op_t    op_o
);

  logic signed [16:0] sc_ext;
  logic signed [16:0] ply_ext;
  logic signed [16:0] sum;
  logic signed [15:0] sc_adj;

  assign busy_o = qstat_i.full | clearing_i;
  assign push_o = start_i & ~busy_o;

  always_comb begin
    sc_ext  = {item_i.score[15], item_i.score};
    ply_ext = {9'd0, item_i.ply_from_root};
    if (sc_ext < MATE_LO) begin
      sum = sc_ext - ply_ext;
    end else if (sc_ext > MATE_HI) begin
      sum = sc_ext + ply_ext;
    end else begin
      sum = sc_ext;
    end
    if (sum > SAT_MAX) begin
      sc_adj = 16'sh7fff;
    end else if (sum < SAT_MIN) begin
      sc_adj = 16'sh8000;
    end else begin
      sc_adj = sum[15:0];
    end
  end

  always_comb begin
    op_o.is_probe     = (item_i.cmd == CMD_PROBE);
    op_o.key          = item_i.key;
    op_o.move         = item_i.best_move;
    op_o.score        = sc_adj;
    op_o.static_score = item_i.static_score;
    op_o.depth        = item_i.search_depth;
    op_o.bound        = item_i.bound_kind;
    op_o.age          = item_i.entry_age;
    op_o.pv           = item_i.on_pv;
  end

endmodule

FILE: hdl/hpt_queue.sv
// hpt_queue: small command queue between front and back
// depends on hpt_pkg
module hpt_queue import hpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hpt_op_t    push_op_i,
  input  logic       pop_i,
  output hpt_op_t    head_o,
  output hpt_qstat_t qstat_o
);

  hpt_op_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign qstat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign head_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

FILE: hdl/hpt_back.sv
// hpt_back: table memories, read-modify-write sequencer and result register
// depends on hpt_pkg
module hpt_back import hpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] cur_gen_i,
  input  hpt_op_t    head_i,
  input  hpt_qstat_t qstat_i,
  output logic       pop_o,
  output logic       clearing_o,
  output logic       done_o,
  output hpt_out_t   result_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;

  logic [63:0] key_mem   [TABLE_ENTRIES];
  logic [31:0] score_mem [TABLE_ENTRIES];
  hpt_meta_t   meta_mem  [TABLE_ENTRIES];

  hpt_op_t     op_q;
  logic [63:0] key_rd_q;
  logic [31:0] score_rd_q;
  hpt_meta_t   meta_rd_q;

  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [63:0]      key_wd;
  logic [31:0]      score_wd;
  hpt_meta_t        meta_wd;

  logic      match;
  logic      do_write;
  logic      done_d;
  logic      done_q;
  hpt_out_t  res_d;
  hpt_out_t  res_q;

  assign rd_en      = (state_q == ST_IDLE) && !qstat_i.empty;
  assign rd_idx     = head_i.key[IDX_W-1:0];
  assign pop_o      = rd_en;
  assign clearing_o = (state_q == ST_CLEAR);
  assign done_o     = done_q;
  assign result_o   = res_q;

  assign match    = meta_rd_q.valid && (key_rd_q == op_q.key);
  assign do_write = !op_q.is_probe &&
                    (!meta_rd_q.valid || (meta_rd_q.depth < op_q.depth) ||
                     (meta_rd_q.age != cur_gen_i));

  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    wr_en     = 1'b0;
    wr_idx    = op_q.key[IDX_W-1:0];
    key_wd    = op_q.key;
    score_wd  = {op_q.score, op_q.static_score};
    meta_wd.move  = (op_q.move == EMPTY_MOVE && match) ? meta_rd_q.move : op_q.move;
    meta_wd.depth = op_q.depth;
    meta_wd.bound = op_q.bound;
    meta_wd.age   = op_q.age;
    meta_wd.pv    = op_q.pv;
    meta_wd.valid = 1'b1;
    done_d    = 1'b0;
    res_d     = '0;

    unique case (state_q)
      ST_CLEAR: begin
        // one entry a cycle, valid bit cleared
        wr_en     = 1'b1;
        wr_idx    = clr_idx_q;
        key_wd    = '0;
        score_wd  = '0;
        meta_wd   = '0;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (rd_en) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (op_q.is_probe) begin
          if (match) begin
            res_d.hit                = 1'b1;
            res_d.found_move         = meta_rd_q.move;
            res_d.found_score        = score_rd_q[31:16];
            res_d.found_static_score = score_rd_q[15:0];
            res_d.found_depth        = {8'd0, meta_rd_q.depth};
            res_d.found_bound        = meta_rd_q.bound;
            res_d.found_pv           = meta_rd_q.pv;
          end else begin
            res_d.hit                = 1'b0;
            res_d.found_move         = EMPTY_MOVE;
            res_d.found_score        = NONE_VAL;
            res_d.found_static_score = NONE_VAL;
            res_d.found_depth        = NONE_VAL;
            res_d.found_bound        = 2'd0;
            res_d.found_pv           = 1'b0;
          end
        end else begin
          wr_en     = do_write;
          res_d.hit = do_write;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_idx]   <= key_wd;
      score_mem[wr_idx] <= score_wd;
      meta_mem[wr_idx]  <= meta_wd;
    end
    if (rd_en) begin
      key_rd_q   <= key_mem[rd_idx];
      score_rd_q <= score_mem[rd_idx];
      meta_rd_q  <= meta_mem[rd_idx];
      op_q       <= head_i;
    end
    res_q <= res_d;
  end

endmodule

FILE: hdl/hashed_position_table.sv
// hashed_position_table: direct-mapped position table, top level
// depends on hpt_pkg, hpt_front, hpt_queue and hpt_back
// path: a start transfer enters the queue; the back end pops it into its read
// registers in ST_IDLE, decides in ST_EVAL and registers the result on done_o;
// one command at a time, reading then updating one entry in the table memories
// reset: a clearing pass over all TABLE_ENTRIES slots clears every valid bit;
// busy stays high meanwhile; the receiver cannot stall, results last one cycle
module hashed_position_table import hpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // command channel
  input  logic       start,
  output logic       busy,
  input  hpt_in_t    item_i,
  // result channel; done_o is a one-cycle strobe per result
  output logic       done_o,
  output hpt_out_t   result_o,
  // current generation register write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  // generation register, compared against stored entry ages
  logic [7:0] cur_gen_q;

  // front to queue
  logic    push;
  hpt_op_t push_op;

  // queue to back
  hpt_op_t    head;
  hpt_qstat_t qstat;
  logic       pop;

  // back status
  logic clearing;

  // config writes land at once; the user must write only while idle, not enforced here
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_gen_q <= 8'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cur_gen_q <= cfg_data_i;
    end
  end

  // accept and classify, adjust mate scores by ply
  hpt_front u_front (
    .start_i    (start),
    .item_i     (item_i),
    .qstat_i    (qstat),
    .clearing_i (clearing),
    .busy_o     (busy),
    .push_o     (push),
    .op_o       (push_op)
  );

  // decouples command transfer from table access
  hpt_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .head_o    (head),
    .qstat_o   (qstat)
  );

  // table memories, replacement decision and result register
  hpt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cur_gen_i  (cur_gen_q),
    .head_i     (head),
    .qstat_i    (qstat),
    .pop_o      (pop),
    .clearing_o (clearing),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule

FILE: tb/tb_hashed_position_table.sv
// tb_hashed_position_table: self-checking testbench for the hashed position table
// depends on hpt_pkg and hashed_position_table; a scoreboard class predicts every
// result, plain tasks drive command transfers and generation writes
`timescale 1ns / 100ps

module tb_hashed_position_table;
  import hpt_pkg::*;

  // bound kind codes as carried in the command
  localparam logic [1:0] BOUND_NIL   = 2'd0;
  localparam logic [1:0] BOUND_UPPER = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;
  localparam logic [1:0] BOUND_EXACT = 2'd3;

  localparam int unsigned TAG_W        = 64 - IDX_W;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 240;
  // reset clearing pass plus ~2000 commands at worst-case gaps, several times over
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // settle time after the last result is back, with margin for the queue path
  localparam int unsigned SETTLE_CYCLES = 4;

  // table model: keeps its own copy of every slot and the current generation,
  // turns each accepted command into the result it must produce
  class position_scoreboard;
    hpt_meta_t          meta_tab   [TABLE_ENTRIES];
    logic [63:0]        key_tab    [TABLE_ENTRIES];
    logic signed [15:0] score_tab  [TABLE_ENTRIES];
    logic signed [15:0] static_tab [TABLE_ENTRIES];
    logic [7:0]         generation;
    hpt_out_t           expected_q [$];
    int unsigned        fail_count;

    function new();
      foreach (meta_tab[i]) begin
        meta_tab[i]   = '0;
        key_tab[i]    = '0;
        score_tab[i]  = '0;
        static_tab[i] = '0;
      end
      generation = '0;
      fail_count = 0;
    endfunction

    function void set_generation(logic [7:0] g);
      generation = g;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_command(hpt_in_t c);
      logic [IDX_W-1:0] slot;
      logic             match;
      logic [15:0]      mv;
      int               adj;
      hpt_out_t         r;
      slot  = c.key[IDX_W-1:0];
      match = meta_tab[slot].valid && (key_tab[slot] == c.key);
      r     = '0;
      if (c.cmd == CMD_STORE) begin
        // mate scores move away from zero by the ply distance
        adj = int'(c.score);
        if (adj < MATE_WINDOW - MATE_SCORE) adj = adj - int'(c.ply_from_root);
        else if (adj > MATE_SCORE - MATE_WINDOW) adj = adj + int'(c.ply_from_root);
        if (adj > 32767) adj = 32767;
        if (adj < -32768) adj = -32768;
        mv = c.best_move;
        if (mv == EMPTY_MOVE && match) mv = meta_tab[slot].move;
        // replace on empty slot, deeper search or stale age
        if (!meta_tab[slot].valid || meta_tab[slot].depth < c.search_depth ||
            meta_tab[slot].age != generation) begin
          key_tab[slot]    = c.key;
          score_tab[slot]  = 16'(adj);
          static_tab[slot] = c.static_score;
          meta_tab[slot]   = '{move: mv, depth: c.search_depth, bound: c.bound_kind,
                               age: c.entry_age, pv: c.on_pv, valid: 1'b1};
          r.hit = 1'b1;
        end
      end else if (match) begin
        r.hit                = 1'b1;
        r.found_move         = meta_tab[slot].move;
        r.found_score        = score_tab[slot];
        r.found_static_score = static_tab[slot];
        r.found_depth        = {8'd0, meta_tab[slot].depth};
        r.found_bound        = meta_tab[slot].bound;
        r.found_pv           = meta_tab[slot].pv;
      end else begin
        r.found_move         = EMPTY_MOVE;
        r.found_score        = NONE_VAL;
        r.found_static_score = NONE_VAL;
        r.found_depth        = NONE_VAL;
      end
      expected_q.push_back(r);
    endfunction

    function void report_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        fail_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(hpt_out_t got);
      hpt_out_t want;
      if (expected_q.size() == 0) begin
        fail_count++;
        $display("%0t: result with no command waiting, expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_q.pop_front();
      report_field("hit", 16'(want.hit), 16'(got.hit));
      report_field("found_move", want.found_move, got.found_move);
      report_field("found_score", want.found_score, got.found_score);
      report_field("found_static_score", want.found_static_score, got.found_static_score);
      report_field("found_depth", want.found_depth, got.found_depth);
      report_field("found_bound", 16'(want.found_bound), 16'(got.found_bound));
      report_field("found_pv", 16'(want.found_pv), 16'(got.found_pv));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  hpt_in_t     item_i;
  logic        done_o;
  hpt_out_t    result_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;

  position_scoreboard positions = new();

  // generation the stimulus currently writes into most entries
  logic [7:0]       cur_gen;
  // small key pools so that stores and probes collide on slots and keys
  logic [IDX_W-1:0] slot_pool [16];
  logic [TAG_W-1:0] tag_pool  [4];
  hpt_in_t          directed_q [$];
  int unsigned      cycle_count = 0;

  hashed_position_table DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // every transfer is observed at the edge that completes it; the values read
  // here are the ones held before the edge, so ordering within the step is moot
  always @(posedge clk_i) begin
    if (start && !busy) positions.note_command(item_i);
    if (cfg_valid_i && cfg_ready_o) positions.set_generation(cfg_data_i);
    if (done_o) positions.check_result(result_o);
  end

  // watchdog for a hung handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hashed_position_table verification failed");
      $finish;
    end
  end

  function automatic hpt_in_t make_cmd(logic is_probe, logic [63:0] key, logic [15:0] move,
                                       int sc, int ss, int dp, logic [1:0] bound,
                                       logic [7:0] age, logic pv, int ply);
    hpt_in_t c;
    c.cmd           = is_probe ? CMD_PROBE : CMD_STORE;
    c.key           = key;
    c.best_move     = move;
    c.score         = 16'(sc);
    c.static_score  = 16'(ss);
    c.search_depth  = 8'(dp);
    c.bound_kind    = bound;
    c.entry_age     = age;
    c.on_pv         = pv;
    c.ply_from_root = 8'(ply);
    return c;
  endfunction

  function automatic hpt_in_t random_cmd();
    hpt_in_t     c;
    int          sc;
    int unsigned pick;
    c.cmd = ($urandom_range(99, 0) < 45) ? CMD_PROBE : CMD_STORE;
    // mostly pooled keys, a few fully random ones that land anywhere
    if ($urandom_range(9, 0) == 0) c.key = {$urandom, $urandom};
    else c.key = {tag_pool[$urandom_range(3, 0)], slot_pool[$urandom_range(15, 0)]};
    c.best_move = ($urandom_range(3, 0) == 0) ? EMPTY_MOVE : 16'($urandom);
    // scores weighted toward the mate ranges and the window boundaries
    pick = $urandom_range(9, 0);
    if (pick < 5) sc = int'($urandom_range(65535, 0)) - 32768;
    else if (pick < 7) sc = int'($urandom_range(32767, 31300));
    else if (pick < 9) sc = -int'($urandom_range(32768, 31300));
    else begin
      sc = (MATE_SCORE - MATE_WINDOW) + int'($urandom_range(1, 0));
      if ($urandom_range(1, 0) == 1) sc = -sc;
    end
    c.score         = 16'(sc);
    c.static_score  = 16'($urandom);
    // shallow depths often, so equal and smaller depths meet on one slot
    c.search_depth  = ($urandom_range(1, 0) == 1) ? 8'($urandom_range(7, 0)) : 8'($urandom);
    c.bound_kind    = 2'($urandom);
    c.entry_age     = ($urandom_range(3, 0) != 0) ? cur_gen : 8'($urandom);
    c.on_pv         = 1'($urandom);
    c.ply_from_root = ($urandom_range(7, 0) == 0) ? 8'd0 : 8'($urandom);
    return c;
  endfunction

  // one command transfer after a random gap; start stays high across
  // back-to-back commands so it is never lowered and raised in one step
  task automatic issue_command(hpt_in_t c, int unsigned max_gap);
    int unsigned gap;
    gap = $urandom_range(max_gap, 0);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= c;
    do @(posedge clk_i); while (busy);
  endtask

  // hold off the command side until every expected result is back
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk_i); while (positions.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_generation(logic [7:0] g);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= g;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_gen = g;
  endtask

  initial begin
    int unsigned max_gap;
    logic [7:0]  phase_gen;

    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    cur_gen     = '0;

    slot_pool[0] = '0;
    slot_pool[1] = '1;
    for (int i = 2; i < 16; i++) slot_pool[i] = IDX_W'($urandom);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    tag_pool[2] = TAG_W'({$urandom, $urandom});
    tag_pool[3] = TAG_W'({$urandom, $urandom});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // generation 0 written explicitly while the table clears
    write_generation(8'h00);

    // probe of a cleared slot: key 0 must not match a slot that was never written
    directed_q.push_back(make_cmd(1, 64'h0, EMPTY_MOVE, 0, 0, 0, BOUND_NIL, 8'h00, 0, 0));
    // positive saturation, all-ones move, top ply
    directed_q.push_back(make_cmd(0, 64'h0, 16'hFFFF, 32767, 32767, 0, BOUND_EXACT,
                                  8'h00, 1, 255));
    directed_q.push_back(make_cmd(1, 64'h0, EMPTY_MOVE, 0, 0, 0, BOUND_NIL, 8'h00, 0, 0));
    // negative saturation on the top slot, deepest depth, foreign age
    directed_q.push_back(make_cmd(0, '1, 16'h1234, -32768, -32768, 255, BOUND_UPPER,
                                  8'hFF, 0, 255));
    directed_q.push_back(make_cmd(1, '1, EMPTY_MOVE, 0, 0, 0, BOUND_NIL, 8'h00, 0, 0));
    // stale age forces the write, empty move keeps the stored one
    directed_q.push_back(make_cmd(0, '1, EMPTY_MOVE, -31501, 0, 3, BOUND_LOWER,
                                  8'h00, 1, 7));
    directed_q.push_back(make_cmd(1, '1, EMPTY_MOVE, 0, 0, 0, BOUND_NIL, 8'h00, 0, 0));
    // equal depth and current age: refused
    directed_q.push_back(make_cmd(0, '1, 16'h00FF, 100, 5, 3, BOUND_EXACT, 8'h00, 0, 0));
    // deeper search: accepted
    directed_q.push_back(make_cmd(0, '1, 16'h00FF, 100, 5, 4, BOUND_EXACT, 8'h00, 0, 0));
    directed_q.push_back(make_cmd(1, '1, EMPTY_MOVE, 0, 0, 0, BOUND_NIL, 8'h00, 0, 0));
    // other key on slot 0: empty move stays empty since the keys differ
    directed_q.push_back(make_cmd(0, 64'h1000, EMPTY_MOVE, 31501, -7, 1, BOUND_LOWER,
                                  8'h00, 0, 5));
    directed_q.push_back(make_cmd(1, 64'h0, EMPTY_MOVE, 0, 0, 0, BOUND_NIL, 8'h00, 0, 0));
    directed_q.push_back(make_cmd(1, 64'h1000, EMPTY_MOVE, 0, 0, 0, BOUND_NIL, 8'h00, 0, 0));
    // window boundaries are left alone, a near-mate score saturates
    directed_q.push_back(make_cmd(0, 64'h2001, 16'h0101, 31500, 1, 0, BOUND_UPPER,
                                  8'h00, 1, 9));
    directed_q.push_back(make_cmd(0, 64'h2002, 16'h0202, -31500, 2, 0, BOUND_LOWER,
                                  8'h00, 0, 9));
    directed_q.push_back(make_cmd(0, 64'h2003, 16'h0303, 32760, 3, 0, BOUND_EXACT,
                                  8'h00, 1, 200));
    directed_q.push_back(make_cmd(1, 64'h2001, EMPTY_MOVE, 0, 0, 0, BOUND_NIL, 8'h00, 0, 0));
    directed_q.push_back(make_cmd(1, 64'h2002, EMPTY_MOVE, 0, 0, 0, BOUND_NIL, 8'h00, 0, 0));
    directed_q.push_back(make_cmd(1, 64'h2003, EMPTY_MOVE, 0, 0, 0, BOUND_NIL, 8'h00, 0, 0));
    directed_q.push_back(make_cmd(0, 64'h2001, 16'h0404, 0, 0, 0, BOUND_NIL, 8'h00, 0, 0));
    // valid slot holding a different key: miss
    directed_q.push_back(make_cmd(1, 64'h3001, EMPTY_MOVE, 0, 0, 0, BOUND_NIL, 8'h00, 0, 0));

    foreach (directed_q[i]) issue_command(directed_q[i], 18);

    // random phases, each under its own generation; the first ones hit the extremes
    for (int p = 0; p < PHASES; p++) begin
      wait_for_results();
      if (p == 0) phase_gen = 8'hFF;
      else if (p == 1) phase_gen = 8'h00;
      else if (p == 2) phase_gen = 8'h01;
      else phase_gen = 8'($urandom);
      write_generation(phase_gen);
      max_gap = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // gap range changes every 40 commands: back-to-back, short and long stretches
        if (i % 40 == 0) begin
          case ($urandom_range(2, 0))
            0:       max_gap = 0;
            1:       max_gap = 3;
            default: max_gap = 18;
          endcase
        end
        issue_command(random_cmd(), max_gap);
      end
    end

    wait_for_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);

    if (positions.fail_count == 0 && positions.pending() == 0) begin
      $display("hashed_position_table verification clean");
    end else begin
      $display("hashed_position_table verification failed");
    end
    $finish;
  end

endmodule
